### rtl/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, constants and the xorshift step for the packet impairment
// decider.
// ----------------------------------------------------------------------------
package pid_pkg;

   localparam int unsigned LENGTH_W  = 16;
   localparam int unsigned SEQ_W     = 32;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned BYTES_W   = 48;
   localparam int unsigned DELAY_W   = 24;
   localparam int unsigned STATE_W   = 64;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [STATE_W-1:0] SEED_VALUE   = 64'h1234_5678_9ABC_DEF0;
   localparam logic [WORD_W-1:0]  BUCKET_RESET = 32'd16384;

   localparam int unsigned XS_SHIFT_A = 13;
   localparam int unsigned XS_SHIFT_B = 7;
   localparam int unsigned XS_SHIFT_C = 17;

   // Item kinds on the request channel
   typedef enum logic {
      KIND_PACKET = 1'b0,
      KIND_TICK   = 1'b1
   } item_kind_type;

   // Register index, taken from csr_paddr[4:2]
   typedef enum logic [2:0] {
      REG_LOSS      = 3'd0,
      REG_REORDER   = 3'd1,
      REG_DUPLICATE = 3'd2,
      REG_DELAY     = 3'd3,
      REG_REFILL    = 3'd4,
      REG_BUCKET    = 3'd5
   } cfg_reg_type;

   // One result item
   typedef struct packed {
      logic                drop_flag;
      logic                queue_flag;
      logic                delay_flag;
      logic                reorder_flag;
      logic                duplicate_flag;
      logic [WORD_W-1:0]   tokens_now;
      logic [WORD_W-1:0]   packets_seen;
      logic [BYTES_W-1:0]  bytes_seen;
      logic [WORD_W-1:0]   drops_seen;
      logic [WORD_W-1:0]   delays_seen;
      logic [WORD_W-1:0]   reorders_seen;
      logic [WORD_W-1:0]   duplicates_seen;
   } rsp_type;

   // One xorshift advance of the random state
   function automatic logic [STATE_W-1:0] xs_step(input logic [STATE_W-1:0] x);
      logic [STATE_W-1:0] a;
      logic [STATE_W-1:0] b;
      a = x ^ (x << XS_SHIFT_A);
      b = a ^ (a >> XS_SHIFT_B);
      return b ^ (b << XS_SHIFT_C);
   endfunction

endpackage

### rtl/pid_req_if.sv
// ----------------------------------------------------------------------------
// pid_req_if
// Request channel: packet arrivals and time ticks.
// ----------------------------------------------------------------------------
interface pid_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [pid_pkg::LENGTH_W-1:0]  packet_length;
   logic [pid_pkg::SEQ_W-1:0]     sequence_number;

   modport source (output valid, output req_type, output packet_length,
                   output sequence_number, input ready);
   modport sink   (input valid, input req_type, input packet_length,
                   input sequence_number, output ready);
endinterface

### rtl/pid_rsp_if.sv
// ----------------------------------------------------------------------------
// pid_rsp_if
// Result channel: impairment flags, bucket level and running counters.
// ----------------------------------------------------------------------------
interface pid_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         drop_flag;
   logic                         queue_flag;
   logic                         delay_flag;
   logic                         reorder_flag;
   logic                         duplicate_flag;
   logic [pid_pkg::WORD_W-1:0]   tokens_now;
   logic [pid_pkg::WORD_W-1:0]   packets_seen;
   logic [pid_pkg::BYTES_W-1:0]  bytes_seen;
   logic [pid_pkg::WORD_W-1:0]   drops_seen;
   logic [pid_pkg::WORD_W-1:0]   delays_seen;
   logic [pid_pkg::WORD_W-1:0]   reorders_seen;
   logic [pid_pkg::WORD_W-1:0]   duplicates_seen;

   modport source (output valid, output drop_flag, output queue_flag,
                   output delay_flag, output reorder_flag, output duplicate_flag,
                   output tokens_now, output packets_seen, output bytes_seen,
                   output drops_seen, output delays_seen, output reorders_seen,
                   output duplicates_seen, input ready);
   modport sink   (input valid, input drop_flag, input queue_flag,
                   input delay_flag, input reorder_flag, input duplicate_flag,
                   input tokens_now, input packets_seen, input bytes_seen,
                   input drops_seen, input delays_seen, input reorders_seen,
                   input duplicates_seen, output ready);
endinterface

### rtl/packet_impairment_decider_top.sv
// ----------------------------------------------------------------------------
// packet_impairment_decider_top
// Per-packet loss, rate-limit, delay, reorder and duplicate decisions.
// ----------------------------------------------------------------------------
// Every request item yields exactly one result item. The block takes one item
// per clock cycle while the result channel is not stalled: the item lands in
// an input register, and a single pass of logic (the 64-bit add of the
// sequence number into the random state, up to three chained xorshift steps
// with their threshold compares, the token bucket compare and the counter
// increments) updates the state and loads the result register. That state
// update loop sets the rate of one item per cycle. A stalled result holds in
// its register while the input register still takes the next item. Registers
// sit on a 32-bit APB-style port at byte address 4*i (loss, reorder,
// duplicate, delay, refill, bucket size); writing the bucket size also fills
// the bucket. Write registers only while the block is idle.
// ----------------------------------------------------------------------------
module packet_impairment_decider_top (
   input  logic                               clock,
   input  logic                               reset,
   pid_req_if.sink                            req_chan,
   pid_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pid_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pid_pkg::WORD_W-1:0]         csr_pwdata,
   output logic [pid_pkg::WORD_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   // ---------------------------------------------------------------- registers
   logic [pid_pkg::WORD_W-1:0]   loss_thr_ff;
   logic [pid_pkg::WORD_W-1:0]   reorder_thr_ff;
   logic [pid_pkg::WORD_W-1:0]   dup_thr_ff;
   logic [pid_pkg::DELAY_W-1:0]  delay_us_ff;
   logic [pid_pkg::WORD_W-1:0]   refill_ff;
   logic [pid_pkg::WORD_W-1:0]   bucket_ff;

   pid_pkg::cfg_reg_type         csr_idx;
   logic                         csr_wr;

   // -------------------------------------------------------------- state
   logic [pid_pkg::STATE_W-1:0]  rand_ff,    rand_in;
   logic [pid_pkg::WORD_W-1:0]   token_ff,   token_in;
   logic [pid_pkg::WORD_W-1:0]   pkt_cnt_ff, pkt_cnt_in;
   logic [pid_pkg::BYTES_W-1:0]  byte_cnt_ff, byte_cnt_in;
   logic [pid_pkg::WORD_W-1:0]   drop_cnt_ff, drop_cnt_in;
   logic [pid_pkg::WORD_W-1:0]   delay_cnt_ff, delay_cnt_in;
   logic [pid_pkg::WORD_W-1:0]   reord_cnt_ff, reord_cnt_in;
   logic [pid_pkg::WORD_W-1:0]   dup_cnt_ff, dup_cnt_in;

   // ------------------------------------------------------------ pipeline
   logic                         s1_valid_ff;
   logic                         s1_type_ff;
   logic [pid_pkg::LENGTH_W-1:0] s1_len_ff;
   logic [pid_pkg::SEQ_W-1:0]    s1_seq_ff;

   logic                         rsp_valid_ff;
   pid_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         out_free;
   logic                         s1_go;
   logic                         req_hs;

   // Working values of the single pass
   logic [pid_pkg::STATE_W-1:0]  mix;
   logic [pid_pkg::STATE_W-1:0]  draw1, draw2, draw3;
   logic [pid_pkg::WORD_W:0]     refill_sum;
   logic [pid_pkg::WORD_W-1:0]   len_ext;
   logic                         drop, queue, delay, reord, dup;

   // ------------------------------------------------------------ handshakes
   // The result register frees when empty or when its item is being taken;
   // the input register advances when it is empty or the result register can load.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_hs         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   // Payload of the input register needs no reset
   always_ff @(posedge clock) begin
      if (req_hs) begin
         s1_type_ff <= req_chan.req_type;
         s1_len_ff  <= req_chan.packet_length;
         s1_seq_ff  <= req_chan.sequence_number;
      end
   end

   // ------------------------------------------------------------ config port
   assign csr_idx    = pid_pkg::cfg_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_thr_ff    <= '0;
         reorder_thr_ff <= '0;
         dup_thr_ff     <= '0;
         delay_us_ff    <= '0;
         refill_ff      <= '0;
         bucket_ff      <= pid_pkg::BUCKET_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            pid_pkg::REG_LOSS:      loss_thr_ff    <= csr_pwdata;
            pid_pkg::REG_REORDER:   reorder_thr_ff <= csr_pwdata;
            pid_pkg::REG_DUPLICATE: dup_thr_ff     <= csr_pwdata;
            pid_pkg::REG_DELAY:     delay_us_ff    <= csr_pwdata[pid_pkg::DELAY_W-1:0];
            pid_pkg::REG_REFILL:    refill_ff      <= csr_pwdata;
            pid_pkg::REG_BUCKET:    bucket_ff      <= csr_pwdata;
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pid_pkg::REG_LOSS:      csr_prdata = loss_thr_ff;
         pid_pkg::REG_REORDER:   csr_prdata = reorder_thr_ff;
         pid_pkg::REG_DUPLICATE: csr_prdata = dup_thr_ff;
         pid_pkg::REG_DELAY:     csr_prdata = {{(pid_pkg::WORD_W - pid_pkg::DELAY_W){1'b0}},
                                               delay_us_ff};
         pid_pkg::REG_REFILL:    csr_prdata = refill_ff;
         pid_pkg::REG_BUCKET:    csr_prdata = bucket_ff;
         default:                csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ single pass
   always_comb begin
      // Hold everything unless the item says otherwise
      rand_in      = rand_ff;
      token_in     = token_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      delay_cnt_in = delay_cnt_ff;
      reord_cnt_in = reord_cnt_ff;
      dup_cnt_in   = dup_cnt_ff;
      drop         = 1'b0;
      queue        = 1'b0;
      delay        = 1'b0;
      reord        = 1'b0;
      dup          = 1'b0;

      len_ext    = {{(pid_pkg::WORD_W - pid_pkg::LENGTH_W){1'b0}}, s1_len_ff};
      refill_sum = {1'b0, token_ff} + {1'b0, refill_ff};

      // Draw chain: each stage advances the state only when enabled
      mix   = rand_ff + {{(pid_pkg::STATE_W - pid_pkg::SEQ_W){1'b0}}, s1_seq_ff};
      draw1 = (loss_thr_ff != '0) ? pid_pkg::xs_step(mix) : mix;
      draw2 = (reorder_thr_ff != '0) ? pid_pkg::xs_step(draw1) : draw1;
      draw3 = (dup_thr_ff != '0) ? pid_pkg::xs_step(draw2) : draw2;

      if (s1_type_ff == pid_pkg::KIND_TICK) begin
         // Refill, saturating at capacity
         if (refill_sum > {1'b0, bucket_ff}) begin
            token_in = bucket_ff;
         end else begin
            token_in = refill_sum[pid_pkg::WORD_W-1:0];
         end
      end else if (s1_len_ff != '0) begin
         pkt_cnt_in  = pkt_cnt_ff + 32'd1;
         byte_cnt_in = byte_cnt_ff + {{(pid_pkg::BYTES_W - pid_pkg::LENGTH_W){1'b0}},
                                      s1_len_ff};
         drop = (loss_thr_ff != '0) && (draw1[63:32] < loss_thr_ff);
         if (drop) begin
            // A dropped packet stops after the loss draw
            rand_in     = draw1;
            drop_cnt_in = drop_cnt_ff + 32'd1;
         end else begin
            rand_in = draw3;
            if (refill_ff != '0) begin
               if (token_ff >= len_ext) begin
                  token_in = token_ff - len_ext;
               end else begin
                  queue = 1'b1;
               end
            end
            delay = (delay_us_ff != '0);
            reord = (reorder_thr_ff != '0) && (draw2[63:32] < reorder_thr_ff);
            dup   = (dup_thr_ff != '0) && (draw3[63:32] < dup_thr_ff);
            if (delay) begin
               delay_cnt_in = delay_cnt_ff + 32'd1;
            end
            if (reord) begin
               reord_cnt_in = reord_cnt_ff + 32'd1;
            end
            if (dup) begin
               dup_cnt_in = dup_cnt_ff + 32'd1;
            end
         end
      end

      rsp_in.drop_flag       = drop;
      rsp_in.queue_flag      = queue;
      rsp_in.delay_flag      = delay;
      rsp_in.reorder_flag    = reord;
      rsp_in.duplicate_flag  = dup;
      rsp_in.tokens_now      = token_in;
      rsp_in.packets_seen    = pkt_cnt_in;
      rsp_in.bytes_seen      = byte_cnt_in;
      rsp_in.drops_seen      = drop_cnt_in;
      rsp_in.delays_seen     = delay_cnt_in;
      rsp_in.reorders_seen   = reord_cnt_in;
      rsp_in.duplicates_seen = dup_cnt_in;
   end

   // ------------------------------------------------------------ state update
   always_ff @(posedge clock) begin
      if (reset) begin
         rand_ff      <= pid_pkg::SEED_VALUE;
         token_ff     <= pid_pkg::BUCKET_RESET;
         pkt_cnt_ff   <= '0;
         byte_cnt_ff  <= '0;
         drop_cnt_ff  <= '0;
         delay_cnt_ff <= '0;
         reord_cnt_ff <= '0;
         dup_cnt_ff   <= '0;
      end else begin
         if (csr_wr && (csr_idx == pid_pkg::REG_BUCKET)) begin
            // Writing the capacity fills the bucket
            token_ff <= csr_pwdata;
         end else if (s1_go) begin
            token_ff <= token_in;
         end
         if (s1_go) begin
            rand_ff      <= rand_in;
            pkt_cnt_ff   <= pkt_cnt_in;
            byte_cnt_ff  <= byte_cnt_in;
            drop_cnt_ff  <= drop_cnt_in;
            delay_cnt_ff <= delay_cnt_in;
            reord_cnt_ff <= reord_cnt_in;
            dup_cnt_ff   <= dup_cnt_in;
         end
      end
   end

   // ------------------------------------------------------------ result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.drop_flag       = rsp_ff.drop_flag;
   assign rsp_chan.queue_flag      = rsp_ff.queue_flag;
   assign rsp_chan.delay_flag      = rsp_ff.delay_flag;
   assign rsp_chan.reorder_flag    = rsp_ff.reorder_flag;
   assign rsp_chan.duplicate_flag  = rsp_ff.duplicate_flag;
   assign rsp_chan.tokens_now      = rsp_ff.tokens_now;
   assign rsp_chan.packets_seen    = rsp_ff.packets_seen;
   assign rsp_chan.bytes_seen      = rsp_ff.bytes_seen;
   assign rsp_chan.drops_seen      = rsp_ff.drops_seen;
   assign rsp_chan.delays_seen     = rsp_ff.delays_seen;
   assign rsp_chan.reorders_seen   = rsp_ff.reorders_seen;
   assign rsp_chan.duplicates_seen = rsp_ff.duplicates_seen;

endmodule

### rtl/pid_checker.sv
// ----------------------------------------------------------------------------
// pid_checker
// Port-level checks on the result channel of the impairment decider.
// ----------------------------------------------------------------------------
module pid_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        drop_flag,
   input logic                        queue_flag,
   input logic                        delay_flag,
   input logic                        reorder_flag,
   input logic                        duplicate_flag,
   input logic [pid_pkg::WORD_W-1:0]  packets_seen,
   input logic [pid_pkg::WORD_W-1:0]  drops_seen,
   input logic [pid_pkg::WORD_W-1:0]  delays_seen
);

   logic rsp_hs;
   assign rsp_hs = rsp_valid && rsp_ready;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drops_seen)
         && $stable(packets_seen) && $stable(drop_flag))
      else $error("result changed while stalled");

   // Result channel is empty straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A dropped packet carries no other impairment
   a_drop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drop_flag |-> !queue_flag && !delay_flag
         && !reorder_flag && !duplicate_flag)
      else $error("dropped packet with further flags");

   // Consecutive results: drop counter steps exactly with the drop flag
   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_hs ##1 rsp_hs |-> drops_seen == $past(drops_seen) + 32'(drop_flag))
      else $error("drop counter out of step");

   // Consecutive results: delay counter steps with the flag, packets by at most one
   a_delay_count: assert property (@(posedge clock) disable iff (reset)
      rsp_hs ##1 rsp_hs |-> (delays_seen == $past(delays_seen) + 32'(delay_flag))
         && ((packets_seen == $past(packets_seen))
            || (packets_seen == $past(packets_seen) + 32'd1)))
      else $error("delay or packet counter out of step");

endmodule

bind packet_impairment_decider_top pid_checker u_pid_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .drop_flag      (rsp_chan.drop_flag),
   .queue_flag     (rsp_chan.queue_flag),
   .delay_flag     (rsp_chan.delay_flag),
   .reorder_flag   (rsp_chan.reorder_flag),
   .duplicate_flag (rsp_chan.duplicate_flag),
   .packets_seen   (rsp_chan.packets_seen),
   .drops_seen     (rsp_chan.drops_seen),
   .delays_seen    (rsp_chan.delays_seen)
);

### verif/packet_impairment_decider_top_test.sv
// ----------------------------------------------------------------------------
// packet_impairment_decider_top_test
// Self-checking bench for the packet impairment decider. A directed table
// covers reset state, field extremes, ticks, zero-length packets, drops,
// queueing, saturation and ignored register indexes. Randomised phases with
// fresh register settings follow. An in-bench model of the xorshift draws,
// token bucket and counters predicts every result, and each result is
// compared field by field.
// ----------------------------------------------------------------------------
module packet_impairment_decider_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEM_TARGET    = 1850;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned PRINT_CAP      = 60;

   // Register indexes beyond the last register: writes there must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   typedef enum logic {
      ROW_ITEM,
      ROW_WRITE
   } row_kind_type;

   typedef enum int {
      SINK_OPEN,
      SINK_CHOPPY,
      SINK_CHOKED
   } sink_mode_type;

   // One line of the directed stimulus table
   typedef struct {
      row_kind_type                   kind;
      pid_pkg::item_kind_type         item;
      logic [pid_pkg::LENGTH_W-1:0]   length;
      logic [pid_pkg::SEQ_W-1:0]      seq;
      logic [2:0]                     reg_idx;
      logic [pid_pkg::WORD_W-1:0]     data;
      logic                           pinned;
      pid_pkg::rsp_type               pin;
   } stim_row_type;

   // Hand-written expectation travelling with an item, if it has one
   typedef struct {
      logic              pinned;
      pid_pkg::rsp_type  value;
   } pin_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [pid_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [pid_pkg::WORD_W-1:0]       csr_pwdata;
   logic [pid_pkg::WORD_W-1:0]       csr_prdata;
   logic                             csr_pready;

   pid_req_if req_bus ();
   pid_rsp_if rsp_bus ();

   packet_impairment_decider_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Decision model: its own copy of the registers and of the block's state
   // -------------------------------------------------------------------------
   logic [pid_pkg::WORD_W-1:0]   cfg_loss;
   logic [pid_pkg::WORD_W-1:0]   cfg_reorder;
   logic [pid_pkg::WORD_W-1:0]   cfg_dup;
   logic [pid_pkg::DELAY_W-1:0]  cfg_delay;
   logic [pid_pkg::WORD_W-1:0]   cfg_refill;
   logic [pid_pkg::WORD_W-1:0]   cfg_bucket;

   logic [pid_pkg::STATE_W-1:0]  model_rand;
   logic [pid_pkg::WORD_W-1:0]   bucket_level;
   logic [pid_pkg::WORD_W-1:0]   pkt_count;
   logic [pid_pkg::BYTES_W-1:0]  byte_count;
   logic [pid_pkg::WORD_W-1:0]   drop_count;
   logic [pid_pkg::WORD_W-1:0]   delay_count;
   logic [pid_pkg::WORD_W-1:0]   reorder_count;
   logic [pid_pkg::WORD_W-1:0]   dup_count;

   pid_pkg::rsp_type  pending_results[$];
   pin_type           pinned_results[$];
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_left = 0;

   // Advance the xorshift state once and hand back its upper word
   function automatic logic [pid_pkg::WORD_W-1:0] next_draw();
      logic [pid_pkg::STATE_W-1:0] x;
      x = model_rand;
      x = x ^ (x << pid_pkg::XS_SHIFT_A);
      x = x ^ (x >> pid_pkg::XS_SHIFT_B);
      x = x ^ (x << pid_pkg::XS_SHIFT_C);
      model_rand = x;
      return x[pid_pkg::STATE_W-1:pid_pkg::WORD_W];
   endfunction

   // Work out the result of one accepted item and update the model state
   function automatic pid_pkg::rsp_type decide_item(pid_pkg::item_kind_type kind,
                                                    logic [pid_pkg::LENGTH_W-1:0] len,
                                                    logic [pid_pkg::SEQ_W-1:0] seq);
      pid_pkg::rsp_type            r;
      logic [pid_pkg::WORD_W:0]    sum;
      logic [pid_pkg::WORD_W-1:0]  len_word;
      r        = '0;
      len_word = {{(pid_pkg::WORD_W - pid_pkg::LENGTH_W){1'b0}}, len};
      if (kind == pid_pkg::KIND_TICK) begin
         // refill, saturating at capacity even when the add overflows 32 bits
         sum = {1'b0, bucket_level} + {1'b0, cfg_refill};
         if (sum > {1'b0, cfg_bucket}) begin
            sum = {1'b0, cfg_bucket};
         end
         bucket_level = sum[pid_pkg::WORD_W-1:0];
      end else if (len != '0) begin
         pkt_count  = pkt_count + 1;
         byte_count = byte_count + {{(pid_pkg::BYTES_W - pid_pkg::LENGTH_W){1'b0}}, len};
         model_rand = model_rand + {{(pid_pkg::STATE_W - pid_pkg::SEQ_W){1'b0}}, seq};
         // each draw happens only when its stage is enabled
         if (cfg_loss != '0) begin
            if (next_draw() < cfg_loss) begin
               r.drop_flag = 1'b1;
               drop_count  = drop_count + 1;
            end
         end
         if (!r.drop_flag) begin
            if (cfg_refill != '0) begin
               if (bucket_level >= len_word) begin
                  bucket_level = bucket_level - len_word;
               end else begin
                  r.queue_flag = 1'b1;
               end
            end
            if (cfg_delay != '0) begin
               r.delay_flag = 1'b1;
               delay_count  = delay_count + 1;
            end
            if (cfg_reorder != '0) begin
               if (next_draw() < cfg_reorder) begin
                  r.reorder_flag = 1'b1;
                  reorder_count  = reorder_count + 1;
               end
            end
            if (cfg_dup != '0) begin
               if (next_draw() < cfg_dup) begin
                  r.duplicate_flag = 1'b1;
                  dup_count        = dup_count + 1;
               end
            end
         end
      end
      r.tokens_now      = bucket_level;
      r.packets_seen    = pkt_count;
      r.bytes_seen      = byte_count;
      r.drops_seen      = drop_count;
      r.delays_seen     = delay_count;
      r.reorders_seen   = reorder_count;
      r.duplicates_seen = dup_count;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want,
                                         logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Table builders for the directed part
   // -------------------------------------------------------------------------
   function automatic stim_row_type item_row(pid_pkg::item_kind_type kind,
                                             logic [pid_pkg::LENGTH_W-1:0] len,
                                             logic [pid_pkg::SEQ_W-1:0] seq);
      stim_row_type row;
      row         = '{default: '0, kind: ROW_ITEM, item: pid_pkg::KIND_PACKET};
      row.item    = kind;
      row.length  = len;
      row.seq     = seq;
      return row;
   endfunction

   function automatic stim_row_type write_row(logic [2:0] idx,
                                              logic [pid_pkg::WORD_W-1:0] data);
      stim_row_type row;
      row         = '{default: '0, kind: ROW_WRITE, item: pid_pkg::KIND_PACKET};
      row.reg_idx = idx;
      row.data    = data;
      return row;
   endfunction

   // Item whose result reads straight off the reset state: no flags, no
   // draws counted, only the bucket level and packet and byte totals set
   function automatic stim_row_type pinned_row(pid_pkg::item_kind_type kind,
                                               logic [pid_pkg::LENGTH_W-1:0] len,
                                               logic [pid_pkg::SEQ_W-1:0] seq,
                                               logic [pid_pkg::WORD_W-1:0] tokens,
                                               logic [pid_pkg::WORD_W-1:0] pkts,
                                               logic [pid_pkg::BYTES_W-1:0] bytes);
      stim_row_type row;
      row                  = item_row(kind, len, seq);
      row.pinned           = 1'b1;
      row.pin              = '0;
      row.pin.tokens_now   = tokens;
      row.pin.packets_seen = pkts;
      row.pin.bytes_seen   = bytes;
      return row;
   endfunction

   function automatic logic [pid_pkg::WORD_W-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return $urandom_range(1, 32'h0FFF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Sender and register port tasks
   // -------------------------------------------------------------------------

   // Hold the sender back until every outstanding result has been taken
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Present one item and hold it until the block accepts it
   task automatic send_item(pid_pkg::item_kind_type kind,
                            logic [pid_pkg::LENGTH_W-1:0] len,
                            logic [pid_pkg::SEQ_W-1:0] seq, logic pinned,
                            pid_pkg::rsp_type pin_value);
      pin_type p;
      p.pinned = pinned;
      p.value  = pin_value;
      pinned_results.push_back(p);
      req_bus.valid           <= 1'b1;
      req_bus.req_type        <= kind;
      req_bus.packet_length   <= len;
      req_bus.sequence_number <= seq;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Setup then access phase; the model takes the value once the block has
   task automatic write_reg(logic [2:0] idx, logic [pid_pkg::WORD_W-1:0] data);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         pid_pkg::REG_LOSS:      cfg_loss    = data;
         pid_pkg::REG_REORDER:   cfg_reorder = data;
         pid_pkg::REG_DUPLICATE: cfg_dup     = data;
         pid_pkg::REG_DELAY:     cfg_delay   = data[pid_pkg::DELAY_W-1:0];
         pid_pkg::REG_REFILL:    cfg_refill  = data;
         pid_pkg::REG_BUCKET: begin
            // a new capacity also fills the bucket
            cfg_bucket   = data;
            bucket_level = data;
         end
         default: ;
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Result sink: stall on a pattern of its own, switching between an open
   // stretch, light random stalls and long stalls
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_left <= $urandom_range(16, 160);
         sink_mode <= sink_mode_type'($urandom_range(0, 2));
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN:   rsp_bus.ready <= 1'b1;
         SINK_CHOPPY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default:     rsp_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // -------------------------------------------------------------------------
   // Monitor: predict on each accepted item, check on each accepted result.
   // Sampled at the clock edge, so the values seen are those before it.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      pin_type pin;
      pid_pkg::rsp_type predicted;
      pid_pkg::rsp_type want;
      pid_pkg::rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = decide_item(pid_pkg::item_kind_type'(req_bus.req_type),
                                    req_bus.packet_length,
                                    req_bus.sequence_number);
            pin = pinned_results.pop_front();
            // a typed-in expectation takes the place of the prediction
            pending_results.push_back(pin.pinned ? pin.value : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.drop_flag       = rsp_bus.drop_flag;
            got.queue_flag      = rsp_bus.queue_flag;
            got.delay_flag      = rsp_bus.delay_flag;
            got.reorder_flag    = rsp_bus.reorder_flag;
            got.duplicate_flag  = rsp_bus.duplicate_flag;
            got.tokens_now      = rsp_bus.tokens_now;
            got.packets_seen    = rsp_bus.packets_seen;
            got.bytes_seen      = rsp_bus.bytes_seen;
            got.drops_seen      = rsp_bus.drops_seen;
            got.delays_seen     = rsp_bus.delays_seen;
            got.reorders_seen   = rsp_bus.reorders_seen;
            got.duplicates_seen = rsp_bus.duplicates_seen;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_CAP) begin
                  $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                           $time, got);
               end
            end else begin
               want = pending_results.pop_front();
               compare_field("drop_flag",       64'(want.drop_flag),
                             64'(got.drop_flag));
               compare_field("queue_flag",      64'(want.queue_flag),
                             64'(got.queue_flag));
               compare_field("delay_flag",      64'(want.delay_flag),
                             64'(got.delay_flag));
               compare_field("reorder_flag",    64'(want.reorder_flag),
                             64'(got.reorder_flag));
               compare_field("duplicate_flag",  64'(want.duplicate_flag),
                             64'(got.duplicate_flag));
               compare_field("tokens_now",      64'(want.tokens_now),
                             64'(got.tokens_now));
               compare_field("packets_seen",    64'(want.packets_seen),
                             64'(got.packets_seen));
               compare_field("bytes_seen",      64'(want.bytes_seen),
                             64'(got.bytes_seen));
               compare_field("drops_seen",      64'(want.drops_seen),
                             64'(got.drops_seen));
               compare_field("delays_seen",     64'(want.delays_seen),
                             64'(got.delays_seen));
               compare_field("reorders_seen",   64'(want.reorders_seen),
                             64'(got.reorders_seen));
               compare_field("duplicates_seen", 64'(want.duplicates_seen),
                             64'(got.duplicates_seen));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles in which nothing moves on any port
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      stim_row_type                   rows[$];
      stim_row_type                   row;
      int unsigned                    items_sent;
      int unsigned                    phase_items;
      int unsigned                    burst;
      int unsigned                    gap;
      int unsigned                    pick;
      bit                             steady;
      pid_pkg::item_kind_type         kind;
      logic [pid_pkg::LENGTH_W-1:0]   len;
      logic [pid_pkg::WORD_W-1:0]     value;

      // Drive every input to a known level from time zero
      reset                   <= 1'b1;
      csr_psel                <= 1'b0;
      csr_penable             <= 1'b0;
      csr_pwrite              <= 1'b0;
      csr_paddr               <= '0;
      csr_pwdata              <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.req_type        <= pid_pkg::KIND_PACKET;
      req_bus.packet_length   <= '0;
      req_bus.sequence_number <= '0;

      // Model starts from the block's reset state
      cfg_loss      = '0;
      cfg_reorder   = '0;
      cfg_dup       = '0;
      cfg_delay     = '0;
      cfg_refill    = '0;
      cfg_bucket    = pid_pkg::BUCKET_RESET;
      model_rand    = pid_pkg::SEED_VALUE;
      bucket_level  = pid_pkg::BUCKET_RESET;
      pkt_count     = '0;
      byte_count    = '0;
      drop_count    = '0;
      delay_count   = '0;
      reorder_count = '0;
      dup_count     = '0;
      items_sent    = 0;

      // Directed table. The first rows run on reset settings, so their
      // results are typed in; the rest go through the model.
      rows.push_back(pinned_row(pid_pkg::KIND_TICK,   16'hFFFF, 32'hFFFF_FFFF,
                                pid_pkg::BUCKET_RESET, 32'd0, 48'd0));
      // zero-length packet: nothing moves, no draw
      rows.push_back(pinned_row(pid_pkg::KIND_PACKET, 16'h0000, 32'hFFFF_FFFF,
                                pid_pkg::BUCKET_RESET, 32'd0, 48'd0));
      rows.push_back(pinned_row(pid_pkg::KIND_PACKET, 16'hFFFF, 32'h0000_0000,
                                pid_pkg::BUCKET_RESET, 32'd1, 48'h00_FFFF));
      rows.push_back(pinned_row(pid_pkg::KIND_PACKET, 16'h0001, 32'hFFFF_FFFF,
                                pid_pkg::BUCKET_RESET, 32'd2, 48'h01_0000));
      // writes past the last register change nothing
      rows.push_back(write_row(REG_SPARE_LO, 32'hFFFF_FFFF));
      rows.push_back(write_row(REG_SPARE_HI, 32'hFFFF_FFFF));
      rows.push_back(pinned_row(pid_pkg::KIND_PACKET, 16'h0002, 32'h0000_0000,
                                pid_pkg::BUCKET_RESET, 32'd3, 48'h01_0002));
      // everything at its maximum: loss drops almost all, tick overflows
      rows.push_back(write_row(pid_pkg::REG_LOSS,      32'hFFFF_FFFF));
      rows.push_back(write_row(pid_pkg::REG_REORDER,   32'hFFFF_FFFF));
      rows.push_back(write_row(pid_pkg::REG_DUPLICATE, 32'hFFFF_FFFF));
      rows.push_back(write_row(pid_pkg::REG_DELAY,     32'hFFFF_FFFF));
      rows.push_back(write_row(pid_pkg::REG_REFILL,    32'hFFFF_FFFF));
      rows.push_back(write_row(pid_pkg::REG_BUCKET,    32'hFFFF_FFFF));
      rows.push_back(item_row(pid_pkg::KIND_TICK,   16'h1234, 32'h5555_AAAA));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'hFFFF, 32'h1234_5678));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'h0000, 32'h0000_0001));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'h0001, 32'hFFFF_FFFF));
      // loss off: survivors go through bucket, delay, reorder and duplicate
      rows.push_back(write_row(pid_pkg::REG_LOSS,      32'h0000_0000));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'hFFFF, 32'h0000_0000));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'h8000, 32'h8000_0000));
      // tiny bucket with slow refill: deduct, queue, refill, empty
      rows.push_back(write_row(pid_pkg::REG_REFILL,    32'd1));
      rows.push_back(write_row(pid_pkg::REG_BUCKET,    32'd100));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd60, 32'h0F0F_0F0F));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd50, 32'hF0F0_F0F0));
      rows.push_back(item_row(pid_pkg::KIND_TICK,   16'd0,  32'd0));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd41, 32'h3333_CCCC));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd1,  32'hCCCC_3333));
      rows.push_back(item_row(pid_pkg::KIND_TICK,   16'd7,  32'd9));
      // rate limiting off, delay off, middling reorder and smallest duplicate threshold
      rows.push_back(write_row(pid_pkg::REG_REORDER,   32'h8000_0000));
      rows.push_back(write_row(pid_pkg::REG_DUPLICATE, 32'h0000_0001));
      rows.push_back(write_row(pid_pkg::REG_DELAY,     32'h0000_0000));
      rows.push_back(write_row(pid_pkg::REG_REFILL,    32'h0000_0000));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd200,   32'hDEAD_0001));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'h7FFF,  32'h0BAD_F00D));
      // empty bucket of zero capacity: a sized packet is queued, tick stays at zero
      rows.push_back(write_row(pid_pkg::REG_REFILL,    32'd5));
      rows.push_back(write_row(pid_pkg::REG_BUCKET,    32'd0));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd1,  32'h0000_00FF));
      rows.push_back(item_row(pid_pkg::KIND_TICK,   16'd0,  32'd0));
      rows.push_back(item_row(pid_pkg::KIND_PACKET, 16'd0,  32'hFFFF_0000));

      // Hold reset once, then release it
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table
      foreach (rows[i]) begin
         row = rows[i];
         if (row.kind == ROW_WRITE) begin
            write_reg(row.reg_idx, row.data);
         end else begin
            send_item(row.item, row.length, row.seq, row.pinned, row.pin);
            items_sent++;
         end
      end

      // Random phases: fresh register settings, then a run of items
      while (items_sent < ITEM_TARGET) begin
         write_reg(pid_pkg::REG_LOSS,      pick_threshold());
         write_reg(pid_pkg::REG_REORDER,   pick_threshold());
         write_reg(pid_pkg::REG_DUPLICATE, pick_threshold());
         case ($urandom_range(0, 3))
            0:       value = '0;
            1:       value = 32'h00FF_FFFF;
            2:       value = 32'd1;
            default: value = $urandom;   // upper byte must be dropped
         endcase
         write_reg(pid_pkg::REG_DELAY, value);
         case ($urandom_range(0, 4))
            0:       value = '0;
            1:       value = 32'd1;
            2:       value = $urandom_range(1, 256);
            3:       value = '1;
            default: value = $urandom;
         endcase
         write_reg(pid_pkg::REG_REFILL, value);
         case ($urandom_range(0, 4))
            0:       value = '0;
            1:       value = $urandom_range(1, 4096);
            2:       value = pid_pkg::BUCKET_RESET;
            3:       value = '1;
            default: value = $urandom;
         endcase
         write_reg(pid_pkg::REG_BUCKET, value);
         if ($urandom_range(0, 3) == 0) begin
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                      $urandom);
         end

         phase_items = $urandom_range(60, 200);
         steady      = ($urandom_range(0, 3) == 0);
         while (phase_items > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && phase_items > 0) begin
               kind = ($urandom_range(0, 3) == 0) ? pid_pkg::KIND_TICK
                                                  : pid_pkg::KIND_PACKET;
               pick = $urandom_range(0, 19);
               if (pick == 0) begin
                  value = '0;
               end else if (pick == 1) begin
                  value = '1;
               end else if (pick < 10) begin
                  value = $urandom_range(1, 64);
               end else if (pick < 16) begin
                  value = $urandom_range(1, 2048);
               end else begin
                  value = $urandom;
               end
               len = value[pid_pkg::LENGTH_W-1:0];
               send_item(kind, len, $urandom, 1'b0, '0);
               burst--;
               phase_items--;
               items_sent++;
            end
            // now and then let the block run dry before going on
            if ($urandom_range(0, 29) == 0) begin
               wait_drained();
            end else if (!steady) begin
               gap = $urandom_range(0, 6);
               if (gap != 0) begin
                  req_bus.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      // Drain, let the pipeline settle, then report
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
